### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion macros, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, ante, cons)
`define ASSERT_NXT(lbl, ante, cons)
`endif
`endif

### hdl/esae_pkg.sv
// ----------------------------------------------------------------------------
// esae_pkg
// Types and constants shared by the encoder speed and acceleration estimator.
// ----------------------------------------------------------------------------
`default_nettype none
package esae_pkg;

  localparam int CNT_W  = 32;
  localparam int NM_W   = 20;
  localparam int CFG_W  = 32;
  localparam int POS_W  = 52;
  localparam int SPD_W  = 56;
  localparam int ACC_W  = 63;
  localparam int TIME_W = 64;
  localparam int RIDX_W = 2;

  localparam logic [RIDX_W-1:0] REG_START_COUNT = 2'd0;
  localparam logic [RIDX_W-1:0] REG_NM_PER_COUNT = 2'd1;
  localparam logic [RIDX_W-1:0] REG_FRAME_TICKS = 2'd2;
  localparam logic [RIDX_W-1:0] REG_TICKS_PER_SEC = 2'd3;

  localparam logic OP_START  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic [63:0] SPEED_MAX   = 64'h00FF_FFFF_FFFF_FFFF;
  localparam logic [63:0] ACC_POS_MAX = 64'h3FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] ACC_NEG_MAX = 64'h4000_0000_0000_0000;

  typedef enum logic [3:0] {
    CMD_IDLE,
    CMD_LATCH,
    CMD_LOAD,
    CMD_SWEEP,
    CMD_CALC,
    CMD_CALC2,
    CMD_SPD_GO,
    CMD_SPD_WAIT,
    CMD_ACC_GO,
    CMD_ACC_WAIT,
    CMD_STORE,
    CMD_RESULT
  } cmd_e;

  typedef struct packed {
    cmd_e cmd;
  } ctrl_t;

  typedef struct packed {
    logic is_start;
    logic sweep_last;
    logic zero_int;
    logic div_done;
    logic out_free;
  } stat_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos;
    logic [TIME_W-1:0]       stamp;
    logic [SPD_W-1:0]        speed;
  } snap_t;

endpackage
`default_nettype wire

### hdl/esae_muldiv.sv
// ----------------------------------------------------------------------------
// esae_muldiv
// Computes a * b / d with a wide product and a bit-serial restoring divider,
// one quotient bit per cycle, flagging quotients that exceed 64 bits.
// ----------------------------------------------------------------------------
`default_nettype none
module esae_muldiv
  import esae_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [SPD_W-1:0]  a_i,
  input  wire logic [CFG_W-1:0]  b_i,
  input  wire logic [TIME_W-1:0] d_i,
  output logic                   done_o,
  output logic [TIME_W-1:0]      q_o,
  output logic                   over_o
);

  typedef enum logic [2:0] {
    D_IDLE,
    D_MUL_LO,
    D_MUL_HI,
    D_SUM,
    D_CHECK,
    D_ITER,
    D_DONE
  } dstate_e;

  dstate_e           state_q;
  logic [5:0]        cnt_q;
  logic [SPD_W-1:0]  a_q;
  logic [CFG_W-1:0]  b_q;
  logic [TIME_W-1:0] d_q;
  logic [63:0]       pl_q;
  logic [55:0]       ph_q;
  logic [TIME_W-1:0] r_q;
  logic [TIME_W-1:0] lo_q;
  logic              over_q;
  logic [87:0]       prod_c;
  logic [64:0]       r65_c;
  logic              ge_c;

  assign prod_c = {24'b0, pl_q} + {ph_q, 32'b0};
  assign r65_c  = {r_q, lo_q[63]};
  assign ge_c   = r65_c >= {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      cnt_q   <= '0;
      over_q  <= 1'b0;
    end else begin
      case (state_q)
        D_IDLE: begin
          if (start_i) begin
            state_q <= D_MUL_LO;
          end
        end
        D_MUL_LO: state_q <= D_MUL_HI;
        D_MUL_HI: state_q <= D_SUM;
        D_SUM:    state_q <= D_CHECK;
        D_CHECK: begin
          over_q  <= r_q >= d_q;
          cnt_q   <= '0;
          state_q <= (r_q >= d_q) ? D_DONE : D_ITER;
        end
        D_ITER: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd63) begin
            state_q <= D_DONE;
          end
        end
        D_DONE:  state_q <= D_IDLE;
        default: state_q <= D_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      D_IDLE: begin
        a_q <= a_i;
        b_q <= b_i;
        d_q <= d_i;
      end
      D_MUL_LO: pl_q <= 64'(a_q[31:0]) * 64'(b_q);
      D_MUL_HI: ph_q <= 56'(a_q[55:32]) * 56'(b_q);
      D_SUM: begin
        r_q  <= 64'(prod_c[87:64]);
        lo_q <= prod_c[63:0];
      end
      D_ITER: begin
        r_q  <= ge_c ? 64'(r65_c - {1'b0, d_q}) : r65_c[63:0];
        lo_q <= {lo_q[62:0], ge_c};
      end
      default: begin
      end
    endcase
  end

  assign done_o = state_q == D_DONE;
  assign q_o    = lo_q;
  assign over_o = over_q;

endmodule
`default_nettype wire

### hdl/esae_dp.sv
// ----------------------------------------------------------------------------
// esae_dp
// Datapath: configuration registers, running time, position scaling, the
// snapshot ring memory, speed and acceleration scaling and the result register.
// ----------------------------------------------------------------------------
`default_nettype none
module esae_dp
  import esae_pkg::*;
#(
  parameter int RING_FRAMES = 8,
  parameter int STAMP_BITS  = 32
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [RIDX_W-1:0]       cfg_idx_i,
  input  wire logic [CFG_W-1:0]        cfg_wdata_i,
  input  wire logic                    opcode_i,
  input  wire logic [CNT_W-1:0]        count_value_i,
  input  wire logic                    moving_backward_i,
  input  wire logic [31:0]             tick_stamp_i,
  input  wire ctrl_t                   ctrl_i,
  output stat_t                        stat_o,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic signed [POS_W-1:0]      position_nm_o,
  output logic                         direction_out_o,
  output logic [SPD_W-1:0]             speed_nm_s_o,
  output logic signed [ACC_W-1:0]      accel_nm_s2_o,
  output logic                         zero_interval_o
);

  localparam int IW = $clog2(RING_FRAMES);
  localparam int SW = (STAMP_BITS < 32) ? STAMP_BITS : 32;

  logic [CNT_W-1:0]  start_count_q;
  logic [NM_W-1:0]   nm_q;
  logic [CFG_W-1:0]  frame_q;
  logic [CFG_W-1:0]  tps_q;

  logic              op_q;
  logic [CNT_W-1:0]  count_q;
  logic              dir_q;
  logic [SW-1:0]     stamp_q;

  logic [IW-1:0]     head_q;
  logic [TIME_W-1:0] running_q;
  logic [SW-1:0]     last_q;
  logic [RING_FRAMES-1:0] vld_q;
  logic              out_valid_q;

  logic [IW-1:0]     sweep_idx_q;
  logic [TIME_W-1:0] sweep_t_q;
  logic [POS_W-1:0]  prod_q;
  logic              pneg_q;
  logic signed [POS_W-1:0] pos_q;
  logic [TIME_W-1:0] elapsed_q;
  logic              zero_q;
  logic [SPD_W-1:0]  mag_q;
  logic              store_q;
  logic [SPD_W-1:0]  speed_q;
  logic [ACC_W-1:0]  acc_q;
  logic              accneg_q;

  snap_t             ring_mem [RING_FRAMES];
  snap_t             rd_old_q;
  snap_t             rd_head_q;
  logic              rv_old_q;
  logic              rv_head_q;
  snap_t             old_c;
  snap_t             head_c;

  logic [IW-1:0]     old_idx_c;
  logic [IW-1:0]     next_head_c;
  logic [STAMP_BITS-1:0] sdiff_c;
  logic [CNT_W-1:0]  cdiff_c;
  logic [CNT_W-1:0]  cmag_c;
  logic [POS_W-1:0]  prod_c;
  logic [TIME_W-1:0] elapsed_c;
  logic signed [POS_W:0] dp_c;
  logic [POS_W:0]    dmag_c;
  logic              sneg_c;
  logic [SPD_W-1:0]  sdm_c;
  logic              we_c;
  logic [IW-1:0]     waddr_c;
  snap_t             wdata_c;
  logic              div_start_c;
  logic [SPD_W-1:0]  div_a_c;
  logic              div_done;
  logic [TIME_W-1:0] div_q;
  logic              div_over;

  assign old_idx_c   = (head_q == IW'(RING_FRAMES - 1)) ? '0 : head_q + 1'b1;
  assign next_head_c = old_idx_c;
  assign sdiff_c     = STAMP_BITS'(stamp_q) - STAMP_BITS'(last_q);
  assign cdiff_c     = count_q - start_count_q;
  assign cmag_c      = cdiff_c[CNT_W-1] ? (~cdiff_c + 1'b1) : cdiff_c;
  assign prod_c      = POS_W'(cmag_c) * POS_W'(nm_q);
  assign old_c       = rv_old_q ? rd_old_q : '0;
  assign head_c      = rv_head_q ? rd_head_q : '0;
  assign elapsed_c   = running_q - old_c.stamp;
  assign dp_c        = (POS_W+1)'(pos_q) - (POS_W+1)'(old_c.pos);
  assign dmag_c      = dp_c[POS_W] ? 53'(-dp_c) : 53'(dp_c);
  assign sneg_c      = speed_q < old_c.speed;
  assign sdm_c       = sneg_c ? (old_c.speed - speed_q) : (speed_q - old_c.speed);
  assign div_start_c = (ctrl_i.cmd == CMD_SPD_GO) || (ctrl_i.cmd == CMD_ACC_GO);
  assign div_a_c     = (ctrl_i.cmd == CMD_ACC_GO) ? sdm_c : mag_q;

  always_comb begin
    we_c    = 1'b0;
    waddr_c = sweep_idx_q;
    wdata_c = '0;
    if (ctrl_i.cmd == CMD_SWEEP) begin
      we_c          = 1'b1;
      wdata_c.stamp = sweep_t_q;
    end else if ((ctrl_i.cmd == CMD_STORE) && store_q) begin
      we_c    = 1'b1;
      waddr_c = next_head_c;
      wdata_c = '{pos: pos_q, stamp: running_q, speed: speed_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_c) begin
      ring_mem[waddr_c] <= wdata_c;
    end
    rd_old_q  <= ring_mem[old_idx_c];
    rd_head_q <= ring_mem[head_q];
  end

  esae_muldiv u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start_c),
    .a_i     (div_a_c),
    .b_i     (tps_q),
    .d_i     (elapsed_q),
    .done_o  (div_done),
    .q_o     (div_q),
    .over_o  (div_over)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_count_q <= '0;
      nm_q          <= NM_W'(1);
      frame_q       <= CFG_W'(1000);
      tps_q         <= CFG_W'(1000000);
      head_q        <= '0;
      running_q     <= '0;
      last_q        <= '0;
      vld_q         <= '0;
      out_valid_q   <= 1'b0;
      rv_old_q      <= 1'b0;
      rv_head_q     <= 1'b0;
    end else begin
      rv_old_q  <= vld_q[old_idx_c];
      rv_head_q <= vld_q[head_q];
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_START_COUNT:   start_count_q <= cfg_wdata_i;
          REG_NM_PER_COUNT:  nm_q          <= cfg_wdata_i[NM_W-1:0];
          REG_FRAME_TICKS:   frame_q       <= cfg_wdata_i;
          REG_TICKS_PER_SEC: tps_q         <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
      if (ctrl_i.cmd == CMD_LOAD) begin
        running_q <= (op_q == OP_START) ? TIME_W'(stamp_q) : running_q + TIME_W'(sdiff_c);
        last_q    <= stamp_q;
      end
      if (we_c) begin
        vld_q[waddr_c] <= 1'b1;
      end
      if ((ctrl_i.cmd == CMD_STORE) && store_q) begin
        head_q <= next_head_c;
      end
      if (ctrl_i.cmd == CMD_RESULT) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (ctrl_i.cmd)
      CMD_LATCH: begin
        op_q    <= opcode_i;
        count_q <= count_value_i;
        dir_q   <= moving_backward_i;
        stamp_q <= tick_stamp_i[SW-1:0];
      end
      CMD_LOAD: begin
        sweep_idx_q <= IW'(RING_FRAMES - 1);
        sweep_t_q   <= TIME_W'(stamp_q) - TIME_W'(frame_q);
        prod_q      <= prod_c;
        pneg_q      <= cdiff_c[CNT_W-1];
        pos_q       <= '0;
        speed_q     <= '0;
        acc_q       <= '0;
        zero_q      <= 1'b0;
      end
      CMD_SWEEP: begin
        sweep_idx_q <= sweep_idx_q - 1'b1;
        sweep_t_q   <= sweep_t_q - TIME_W'(frame_q);
      end
      CMD_CALC: pos_q <= pneg_q ? -$signed(prod_q) : $signed(prod_q);
      CMD_CALC2: begin
        elapsed_q <= elapsed_c;
        zero_q    <= elapsed_c == '0;
        mag_q     <= SPD_W'(dmag_c);
        store_q   <= (running_q - head_c.stamp) >= TIME_W'(frame_q);
      end
      CMD_SPD_WAIT: begin
        if (div_done) begin
          speed_q <= (div_over || (div_q > SPEED_MAX)) ? SPEED_MAX[SPD_W-1:0]
                                                       : div_q[SPD_W-1:0];
        end
      end
      CMD_ACC_GO: accneg_q <= sneg_c;
      CMD_ACC_WAIT: begin
        if (div_done) begin
          if (accneg_q) begin
            acc_q <= (div_over || (div_q > ACC_NEG_MAX)) ? ACC_W'(-ACC_NEG_MAX)
                                                         : ACC_W'(-div_q);
          end else begin
            acc_q <= (div_over || (div_q > ACC_POS_MAX)) ? ACC_POS_MAX[ACC_W-1:0]
                                                         : div_q[ACC_W-1:0];
          end
        end
      end
      CMD_RESULT: begin
        position_nm_o   <= pos_q;
        direction_out_o <= dir_q;
        speed_nm_s_o    <= speed_q;
        accel_nm_s2_o   <= acc_q;
        zero_interval_o <= zero_q;
      end
      default: begin
      end
    endcase
  end

  assign stat_o.is_start   = op_q == OP_START;
  assign stat_o.sweep_last = sweep_idx_q == '0;
  assign stat_o.zero_int   = zero_q;
  assign stat_o.div_done   = div_done;
  assign stat_o.out_free   = !out_valid_q || !out_stall_i;
  assign out_valid_o       = out_valid_q;

endmodule
`default_nettype wire

### hdl/esae_ctrl.sv
// ----------------------------------------------------------------------------
// esae_ctrl
// Controller: sequences the datapath through one start or sample word.
// ----------------------------------------------------------------------------
`default_nettype none
module esae_ctrl
  import esae_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_stall_o,
  input  wire stat_t stat_i,
  output ctrl_t      ctrl_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_SWEEP,
    S_CALC,
    S_CALC2,
    S_SPD_GO,
    S_SPD_WAIT,
    S_ACC_GO,
    S_ACC_WAIT,
    S_STORE,
    S_DONE
  } state_e;

  state_e state_q;
  state_e state_d;

  always_comb begin
    state_d    = state_q;
    ctrl_o.cmd = CMD_IDLE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.cmd = CMD_LATCH;
          state_d    = S_LOAD;
        end
      end
      S_LOAD: begin
        ctrl_o.cmd = CMD_LOAD;
        state_d    = stat_i.is_start ? S_SWEEP : S_CALC;
      end
      S_SWEEP: begin
        ctrl_o.cmd = CMD_SWEEP;
        if (stat_i.sweep_last) begin
          state_d = S_DONE;
        end
      end
      S_CALC: begin
        ctrl_o.cmd = CMD_CALC;
        state_d    = S_CALC2;
      end
      S_CALC2: begin
        ctrl_o.cmd = CMD_CALC2;
        state_d    = S_SPD_GO;
      end
      S_SPD_GO: begin
        if (stat_i.zero_int) begin
          state_d = S_STORE;
        end else begin
          ctrl_o.cmd = CMD_SPD_GO;
          state_d    = S_SPD_WAIT;
        end
      end
      S_SPD_WAIT: begin
        ctrl_o.cmd = CMD_SPD_WAIT;
        if (stat_i.div_done) begin
          state_d = S_ACC_GO;
        end
      end
      S_ACC_GO: begin
        ctrl_o.cmd = CMD_ACC_GO;
        state_d    = S_ACC_WAIT;
      end
      S_ACC_WAIT: begin
        ctrl_o.cmd = CMD_ACC_WAIT;
        if (stat_i.div_done) begin
          state_d = S_STORE;
        end
      end
      S_STORE: begin
        ctrl_o.cmd = CMD_STORE;
        state_d    = S_DONE;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          ctrl_o.cmd = CMD_RESULT;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = state_q != S_IDLE;

endmodule
`default_nettype wire

### hdl/encoder_speed_accel_estimator_unit.sv
// ----------------------------------------------------------------------------
// encoder_speed_accel_estimator_unit
// Windowed encoder speed and acceleration estimator with a snapshot ring.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake               Payload
//  in       input      in_valid_i / in_stall_o  opcode, count, direction, stamp
//  out      output     out_valid_o / out_stall_i position, direction, speed, accel, flag
//  cfg      input      cfg_we_i                 cfg_idx_i, cfg_wdata_i
//
// A sample word with a nonzero interval passes twice through the
// bit-serial divider, which resolves one quotient bit per cycle.
// A start word writes all RING_FRAMES ring entries, one ring entry per cycle.
// Reset marks every ring entry empty at once; an empty entry reads as zero.
// A finished word waits in the output register while the next word is taken.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module encoder_speed_accel_estimator_unit
  import esae_pkg::*;
#(
  parameter int RING_FRAMES = 8,
  parameter int STAMP_BITS  = 32
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [RIDX_W-1:0]   cfg_idx_i,
  input  wire logic [CFG_W-1:0]    cfg_wdata_i,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic                opcode_i,
  input  wire logic [CNT_W-1:0]    count_value_i,
  input  wire logic                moving_backward_i,
  input  wire logic [31:0]         tick_stamp_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic signed [POS_W-1:0]  position_nm_o,
  output logic                     direction_out_o,
  output logic [SPD_W-1:0]         speed_nm_s_o,
  output logic signed [ACC_W-1:0]  accel_nm_s2_o,
  output logic                     zero_interval_o
);

  ctrl_t ctrl;
  stat_t stat;

  esae_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  esae_dp #(
    .RING_FRAMES (RING_FRAMES),
    .STAMP_BITS  (STAMP_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .opcode_i          (opcode_i),
    .count_value_i     (count_value_i),
    .moving_backward_i (moving_backward_i),
    .tick_stamp_i      (tick_stamp_i),
    .ctrl_i            (ctrl),
    .stat_o            (stat),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .position_nm_o     (position_nm_o),
    .direction_out_o   (direction_out_o),
    .speed_nm_s_o      (speed_nm_s_o),
    .accel_nm_s2_o     (accel_nm_s2_o),
    .zero_interval_o   (zero_interval_o)
  );

  `ASSERT_NXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)
  `ASSERT_IMP(a_zero_gives_no_motion, out_valid_o && zero_interval_o, speed_nm_s_o == '0 && accel_nm_s2_o == '0)
  `ASSERT_IMP(a_result_only_when_free, ctrl.cmd == CMD_RESULT, stat.out_free)

endmodule
`default_nettype wire

### tb/encoder_speed_accel_estimator_unit_tb.sv
// ----------------------------------------------------------------------------
// encoder_speed_accel_estimator_unit_tb
// Self-checking bench for the encoder speed and acceleration estimator. Each
// accepted word is run through a behavioural estimator kept in the bench; each
// result word is compared field by field with the oldest estimate or typed row.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module encoder_speed_accel_estimator_unit_tb;
  import esae_pkg::*;

  localparam int FRAMES = 8;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic             bwd;
    logic [SPD_W-1:0] spd;
    logic [ACC_W-1:0] acc;
    logic             zi;
  } motion_t;

  typedef struct packed {
    logic             op;
    logic [31:0]      cnt;
    logic             bwd;
    logic [31:0]      stamp;
    logic             typed;
    logic [POS_W-1:0] pos;
    logic             zi;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [RIDX_W-1:0] cfg_idx_i = REG_START_COUNT;
  logic [CFG_W-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic opcode_i = OP_START;
  logic [CNT_W-1:0] count_value_i = '0;
  logic moving_backward_i = 1'b0;
  logic [31:0] tick_stamp_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [POS_W-1:0] position_nm_o;
  logic direction_out_o;
  logic [SPD_W-1:0] speed_nm_s_o;
  logic signed [ACC_W-1:0] accel_nm_s2_o;
  logic zero_interval_o;

  encoder_speed_accel_estimator_unit dut (.*);

  // Estimator state
  logic [63:0] start_cnt, nm_scale, frame_len, tick_rate;
  logic signed [63:0] ring_pos [FRAMES];
  logic [63:0] ring_time [FRAMES];
  logic [63:0] ring_spd [FRAMES];
  int unsigned head_idx;
  logic [63:0] run_ticks;
  logic [31:0] prev_stamp;

  motion_t pending_results[$];
  int errors = 0;
  int in_idle_pct = 0;
  int rx_stall_pct = 0;
  int rx_hold_left = 0;
  int hold_req = 0;
  int hold_seen = 0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #40ms;
    $display("status: fail");
    $finish;
  end

  function automatic logic [63:0] scaled_ratio(input logic [63:0] a, input logic [63:0] b,
                                               input logic [63:0] d, output logic over);
    logic [127:0] q;
    q = ({64'b0, a} * {64'b0, b}) / {64'b0, d};
    over = |q[127:64];
    return q[63:0];
  endfunction

  function automatic motion_t estimate(input logic op, input logic [31:0] cnt,
                                       input logic bwd, input logic [31:0] stamp);
    motion_t r;
    logic [31:0] diff;
    logic signed [63:0] pos, dp;
    logic [63:0] elapsed, mag, spd, acc, dm, a;
    int unsigned oldest;
    logic over, neg;
    r = '0;
    r.bwd = bwd;
    if (op == OP_START) begin
      for (int i = 0; i < FRAMES; i++) begin
        ring_pos[i] = 0;
        ring_spd[i] = 0;
        ring_time[i] = {32'b0, stamp} - 64'(FRAMES - i) * frame_len;
      end
      run_ticks = {32'b0, stamp};
      prev_stamp = stamp;
      return r;
    end
    oldest = (head_idx + 1) % FRAMES;
    run_ticks = run_ticks + {32'b0, stamp - prev_stamp};
    prev_stamp = stamp;
    diff = cnt - start_cnt[31:0];
    if (diff[31]) pos = -$signed(({32'b0, ~diff} + 64'd1) * nm_scale);
    else pos = $signed({32'b0, diff} * nm_scale);
    spd = 0;
    acc = 0;
    elapsed = run_ticks - ring_time[oldest];
    if (elapsed == 0) begin
      r.zi = 1'b1;
    end else if (tick_rate != 0) begin
      dp = pos - ring_pos[oldest];
      mag = dp < 0 ? -dp : dp;
      spd = scaled_ratio(mag, tick_rate, elapsed, over);
      if (over || spd > SPEED_MAX) spd = SPEED_MAX;
      neg = spd < ring_spd[oldest];
      dm = neg ? ring_spd[oldest] - spd : spd - ring_spd[oldest];
      a = scaled_ratio(dm, tick_rate, elapsed, over);
      if (neg) begin
        if (over || a > ACC_NEG_MAX) a = ACC_NEG_MAX;
        acc = -a;
      end else begin
        acc = (over || a > ACC_POS_MAX) ? ACC_POS_MAX : a;
      end
    end
    r.pos = pos[POS_W-1:0];
    r.spd = spd[SPD_W-1:0];
    r.acc = acc[ACC_W-1:0];
    if (run_ticks - ring_time[head_idx] >= frame_len) begin
      head_idx = (head_idx + 1) % FRAMES;
      ring_pos[head_idx] = pos;
      ring_time[head_idx] = run_ticks;
      ring_spd[head_idx] = spd;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    errors++;
    $display("mismatch %s: got %h expected %h", what, got, want);
  endtask

  // Result side: random stalls, a counted long hold-off, and the checks.
  always @(posedge clk_i) begin
    motion_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word", 0, 0);
      end else begin
        e = pending_results.pop_front();
        if (position_nm_o !== e.pos) report_mismatch("position", position_nm_o, e.pos);
        if (direction_out_o !== e.bwd) report_mismatch("direction", direction_out_o, e.bwd);
        if (speed_nm_s_o !== e.spd) report_mismatch("speed", speed_nm_s_o, e.spd);
        if (accel_nm_s2_o !== e.acc) report_mismatch("accel", accel_nm_s2_o, e.acc);
        if (zero_interval_o !== e.zi) report_mismatch("zero interval", zero_interval_o, e.zi);
      end
    end
    if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      rx_hold_left <= 3000;
      out_stall_i <= 1'b1;
    end else if (rx_hold_left > 0) begin
      rx_hold_left <= rx_hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  task automatic send_word(input logic op, input logic [31:0] cnt, input logic bwd,
                           input logic [31:0] stamp, input logic typed, input motion_t want);
    motion_t r;
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < in_idle_pct);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    count_value_i <= cnt;
    moving_backward_i <= bwd;
    tick_stamp_i <= stamp;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    r = estimate(op, cnt, bwd, stamp);
    pending_results.push_back(typed ? want : r);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [RIDX_W-1:0] idx, input logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_START_COUNT:   start_cnt = {32'b0, val};
      REG_NM_PER_COUNT:  nm_scale = {44'b0, val[19:0]};
      REG_FRAME_TICKS:   frame_len = {32'b0, val};
      REG_TICKS_PER_SEC: tick_rate = {32'b0, val};
      default: ;
    endcase
  endtask

  initial begin
    row_t rows [12];
    motion_t want;
    logic [31:0] stamp_now, cnt_now, vel, sc, nm, fr, tps;
    int unsigned roll;
    rows = '{
      '{OP_SAMPLE, 32'd5,          1'b0, 32'd0,          1'b1, 52'd5,   1'b1},
      '{OP_SAMPLE, 32'hFFFF_FFFF,  1'b1, 32'd0,          1'b1, '1,      1'b1},
      '{OP_START,  32'd0,          1'b1, 32'd100,        1'b1, 52'd0,   1'b0},
      '{OP_SAMPLE, 32'd1000,       1'b0, 32'd600,        1'b0, 52'd0,   1'b0},
      '{OP_SAMPLE, 32'd3000,       1'b0, 32'd1600,       1'b0, 52'd0,   1'b0},
      '{OP_SAMPLE, 32'h8000_0000,  1'b1, 32'd2700,       1'b0, 52'd0,   1'b0},
      '{OP_SAMPLE, 32'h7FFF_FFFF,  1'b0, 32'd3800,       1'b0, 52'd0,   1'b0},
      '{OP_START,  32'd7,          1'b0, 32'hFFFF_FF00,  1'b1, 52'd0,   1'b0},
      '{OP_SAMPLE, 32'd10,         1'b0, 32'h0000_0200,  1'b0, 52'd0,   1'b0},
      '{OP_SAMPLE, 32'd20,         1'b1, 32'hFFFF_FFFF,  1'b0, 52'd0,   1'b0},
      '{OP_SAMPLE, 32'd0,          1'b0, 32'hFFFF_FFFF,  1'b0, 52'd0,   1'b0},
      '{OP_START,  32'hFFFF_FFFF,  1'b1, 32'd0,          1'b1, 52'd0,   1'b0}
    };
    for (int i = 0; i < FRAMES; i++) begin
      ring_pos[i] = 0;
      ring_time[i] = 0;
      ring_spd[i] = 0;
    end
    head_idx = 0;
    run_ticks = 0;
    prev_stamp = 0;
    start_cnt = 0;
    nm_scale = 1;
    frame_len = 1000;
    tick_rate = 1000000;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      want = '0;
      want.pos = rows[i].pos;
      want.bwd = rows[i].bwd;
      want.zi = rows[i].zi;
      send_word(rows[i].op, rows[i].cnt, rows[i].bwd, rows[i].stamp, rows[i].typed, want);
    end
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin sc = 0; nm = 1; fr = 1000; tps = 1000000; end
        1: begin sc = 32'hFFFF_FFFF; nm = 20'hFFFFF; fr = 1; tps = 32'hFFFF_FFFF; end
        2: begin sc = 0; nm = 1; fr = 32'hFFFF_FFFF; tps = 1; end
        default: begin
          sc = $urandom;
          nm = $urandom_range(20'hFFFFF, 1);
          fr = $urandom_range(5000, 1);
          tps = $urandom_range(32'hFFFF_FFFF, 1);
        end
      endcase
      write_reg(REG_START_COUNT, sc);
      write_reg(REG_NM_PER_COUNT, nm);
      write_reg(REG_FRAME_TICKS, fr);
      write_reg(REG_TICKS_PER_SEC, tps);
      case (ph / 2)
        0: begin in_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin in_idle_pct = 70; rx_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  rx_stall_pct = 70; end
        default: begin in_idle_pct = 14; rx_stall_pct = 14; end
      endcase
      stamp_now = $urandom;
      cnt_now = sc + $urandom_range(2000);
      vel = $urandom_range(400) - 200;
      send_word(OP_START, cnt_now, 1'b0, stamp_now, 1'b0, '0);
      for (int n = 0; n < 170; n++) begin
        if (n == 60 && ph == 1) hold_req = hold_req + 1;
        if (n == 110) begin
          in_valid_i <= 1'b0;
          @(posedge clk_i);
          while (pending_results.size() != 0) @(posedge clk_i);
        end
        roll = $urandom_range(99);
        if (roll < 3) begin
          stamp_now = stamp_now + $urandom_range(3000);
          send_word(OP_START, cnt_now, 1'($urandom_range(1)), stamp_now, 1'b0, '0);
        end else if (roll < 13) begin
          stamp_now = $urandom;
          cnt_now = $urandom;
          send_word(OP_SAMPLE, cnt_now, 1'($urandom_range(1)), stamp_now, 1'b0, '0);
        end else begin
          if ($urandom_range(9) == 0) vel = $urandom;
          else if ($urandom_range(9) == 0) vel = $urandom_range(400) - 200;
          roll = $urandom_range(9);
          if (roll == 0) stamp_now = stamp_now;
          else if (roll < 8) stamp_now = stamp_now + $urandom_range(2 * fr + 1);
          else stamp_now = stamp_now + $urandom;
          cnt_now = cnt_now + vel;
          send_word(OP_SAMPLE, cnt_now, vel[31], stamp_now, 1'b0, '0);
        end
      end
      drain();
    end

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire

### filelist.f
+incdir+hdl
hdl/esae_pkg.sv
hdl/esae_muldiv.sv
hdl/esae_dp.sv
hdl/esae_ctrl.sv
hdl/encoder_speed_accel_estimator_unit.sv
tb/encoder_speed_accel_estimator_unit_tb.sv
